@@ rtl/ttip_pkg.sv @@
// types and constants shared by the text-to-integer parser
// parse phase enum, state and result structs, character codes, digit decode
// no dependencies
package ttip_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_HEXPRE = 3'd3,
        PH_DIGITS = 3'd4,
        PH_SKIP   = 3'd5
    } ttip_phase_t;

    typedef struct packed {
        ttip_phase_t phase;
        logic [63:0] acc;
        logic        minus;
        logic        digit;
        logic [5:0]  base;
    } ttip_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] offset;
        logic        conv;
    } ttip_result_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } ttip_digit_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [7:0] LETTER_OFS = 8'd10;

    // value of an alphanumeric character, 0..35
    function automatic ttip_digit_t digit_of(input logic [7:0] c);
        ttip_digit_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
            r.val = 6'(c - CH_ZERO);
        else if (c >= CH_LA && c <= CH_LZ)
            r.val = 6'(c - CH_LA + LETTER_OFS);
        else if (c >= CH_UA && c <= CH_UZ)
            r.val = 6'(c - CH_UA + LETTER_OFS);
        else
            r.ok = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/ttip_step.sv @@
// per-character parse step: next state, position count and result of one beat
// pure combinational; uses ttip_pkg
module ttip_step #(
    parameter int OFFSET_BITS = 16
) (
    input  ttip_pkg::ttip_state_t  st,
    input  logic [OFFSET_BITS-1:0] pos,
    input  logic [7:0]             char_in,
    input  logic [5:0]             base_cfg,
    output ttip_pkg::ttip_state_t  st_next,
    output logic [OFFSET_BITS-1:0] pos_next,
    output logic                   emit,
    output ttip_pkg::ttip_result_t res
);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    ttip_pkg::ttip_digit_t  dig;
    logic                   is_ws;
    logic                   is_sign;
    logic                   first_zero;
    logic [5:0]             first_eff;
    logic                   take_ok;
    logic [63:0]            mul_acc;
    logic [1:0]             cnt_inc;
    logic [OFFSET_BITS:0]   pos_sum;
    logic                   clear;
    logic [31:0]            off_ext;

    assign dig        = ttip_pkg::digit_of(char_in);
    assign is_ws      = (char_in == ttip_pkg::CH_SPACE) ||
                        (char_in >= ttip_pkg::CH_TAB && char_in <= ttip_pkg::CH_CR);
    assign is_sign    = (char_in == ttip_pkg::CH_PLUS) || (char_in == ttip_pkg::CH_MINUS);
    assign first_zero = ((base_cfg == ttip_pkg::BASE_AUTO) ||
                         (base_cfg == ttip_pkg::BASE_HEX)) &&
                        (char_in == ttip_pkg::CH_ZERO);
    assign first_eff  = (base_cfg == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC : base_cfg;
    assign take_ok    = dig.ok && (dig.val < st.base);
    // 64 x 6 multiply-add, wraps modulo 2^64
    assign mul_acc    = st.acc * 64'(st.base) + 64'(dig.val);
    assign pos_sum    = {1'b0, pos} + {{(OFFSET_BITS-1){1'b0}}, cnt_inc};

    always_comb
    begin
        st_next = st;
        cnt_inc = 2'd0;
        emit    = 1'b0;
        clear   = 1'b0;
        unique case (st.phase)
            ttip_pkg::PH_LEAD, ttip_pkg::PH_SIGNED:
            begin
                priority if (st.phase == ttip_pkg::PH_LEAD && is_ws)
                begin
                    cnt_inc = 2'd1;
                end
                else if (st.phase == ttip_pkg::PH_LEAD && is_sign)
                begin
                    st_next.minus = (char_in == ttip_pkg::CH_MINUS);
                    st_next.phase = ttip_pkg::PH_SIGNED;
                    cnt_inc       = 2'd1;
                end
                else if (first_zero)
                begin
                    st_next.base  = (base_cfg == ttip_pkg::BASE_HEX) ?
                                    ttip_pkg::BASE_HEX : ttip_pkg::BASE_OCT;
                    st_next.acc   = 64'd0;
                    st_next.digit = 1'b1;
                    st_next.phase = ttip_pkg::PH_ZERO;
                    cnt_inc       = 2'd1;
                end
                else
                begin
                    st_next.base = first_eff;
                    if (dig.ok && dig.val < first_eff)
                    begin
                        st_next.acc   = 64'(dig.val);
                        st_next.digit = 1'b1;
                        st_next.phase = ttip_pkg::PH_DIGITS;
                        cnt_inc       = 2'd1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            ttip_pkg::PH_ZERO:
            begin
                // the x is counted only once a hex digit follows
                if (char_in == ttip_pkg::CH_LX || char_in == ttip_pkg::CH_UX)
                begin
                    st_next.base  = ttip_pkg::BASE_HEX;
                    st_next.phase = ttip_pkg::PH_HEXPRE;
                end
                else if (take_ok)
                begin
                    st_next.acc   = mul_acc;
                    st_next.digit = 1'b1;
                    st_next.phase = ttip_pkg::PH_DIGITS;
                    cnt_inc       = 2'd1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            ttip_pkg::PH_HEXPRE:
            begin
                if (dig.ok && dig.val < ttip_pkg::BASE_HEX)
                begin
                    st_next.acc   = 64'(dig.val);
                    st_next.phase = ttip_pkg::PH_DIGITS;
                    cnt_inc       = 2'd2;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            ttip_pkg::PH_DIGITS:
            begin
                if (take_ok)
                begin
                    st_next.acc   = mul_acc;
                    st_next.digit = 1'b1;
                    cnt_inc       = 2'd1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                // skipping the tail of the string
                clear = (char_in == ttip_pkg::CH_NUL);
            end
        endcase

        if (emit)
        begin
            if (char_in == ttip_pkg::CH_NUL)
                clear = 1'b1;
            else
                st_next.phase = ttip_pkg::PH_SKIP;
        end

        if (clear)
        begin
            st_next.phase = ttip_pkg::PH_LEAD;
            st_next.acc   = 64'd0;
            st_next.minus = 1'b0;
            st_next.digit = 1'b0;
            st_next.base  = 6'd0;
        end
    end

    assign pos_next = clear ? '0 :
                      pos_sum[OFFSET_BITS] ? OFFSET_MAX : pos_sum[OFFSET_BITS-1:0];

    // result fields always reflect the state before this character
    assign off_ext    = 32'(pos);
    assign res.value  = st.minus ? (~st.acc + 64'd1) : st.acc;
    assign res.offset = !st.digit ? 16'd0 :
                        (off_ext > 32'h0000_FFFF) ? 16'hFFFF : off_ext[15:0];
    assign res.conv   = st.digit;

endmodule

@@ rtl/text_to_integer_parser_core.sv @@
// streaming strtoull-style parser: input beat register, parse state, result register
// uses ttip_pkg and ttip_step
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  config  | cfg_write, number_base               | in
//  input   | in_valid, in_stall, char_code        | in beat, stall out
//  output  | out_valid, out_stall, parsed_value,  | out beat, stall in
//          | end_offset, converted                |
//
// one character per cycle sustained while out_stall is low; a result is loaded into the
// result register when its character is consumed from the input register. the per-beat path is
// the 64 x 6 multiply-add of the accumulator. reset clears the base register to 0 (auto
// detect) and the parse state. a stalled result holds the result register; the input
// register then holds its beat and in_stall rises until the result is taken.
module text_to_integer_parser_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [5:0]  number_base,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] parsed_value,
    output logic [15:0] end_offset,
    output logic        converted
);

    logic [5:0]             base_reg;
    logic                   in_vld_reg;
    logic [7:0]             char_reg;
    ttip_pkg::ttip_state_t  st_reg;
    ttip_pkg::ttip_state_t  st_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   out_vld_reg;
    ttip_pkg::ttip_result_t res_reg;
    ttip_pkg::ttip_result_t res_next;
    logic                   emit;
    logic                   consume;
    logic                   in_take;

    // the buffered beat is parsed when the result register is free or being emptied
    assign consume  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !consume;
    assign in_take  = in_valid && !in_stall;

    ttip_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .st       (st_reg),
        .pos      (pos_reg),
        .char_in  (char_reg),
        .base_cfg (base_reg),
        .st_next  (st_next),
        .pos_next (pos_next),
        .emit     (emit),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= 6'd0;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            st_reg.phase <= ttip_pkg::PH_LEAD;
            st_reg.acc   <= 64'd0;
            st_reg.minus <= 1'b0;
            st_reg.digit <= 1'b0;
            st_reg.base  <= 6'd0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
                base_reg <= number_base;
            if (in_take || consume)
                in_vld_reg <= in_take;
            if (consume)
            begin
                st_reg  <= st_next;
                pos_reg <= pos_next;
            end
            if (consume && emit)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            char_reg <= char_code;
        if (consume && emit)
            res_reg <= res_next;
    end

    assign out_valid    = out_vld_reg;
    assign parsed_value = res_reg.value;
    assign end_offset   = res_reg.offset;
    assign converted    = res_reg.conv;

    // a result without a converted digit carries zero value and zero offset
    a_noconv_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_reg.conv |-> res_reg.value == 64'd0 && res_reg.offset == 16'd0)
        else $error("unconverted result with nonzero value or offset");

    // a string terminator always returns the parser to a clean start
    a_nul_clears : assert property (@(posedge clk) disable iff (!rst_n)
        consume && char_reg == ttip_pkg::CH_NUL |=>
            st_reg.phase == ttip_pkg::PH_LEAD && pos_reg == '0 && !st_reg.digit)
        else $error("terminator did not clear parse state");

    // accumulating digits implies a digit was seen
    a_digits_seen : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == ttip_pkg::PH_DIGITS || st_reg.phase == ttip_pkg::PH_ZERO ||
        st_reg.phase == ttip_pkg::PH_HEXPRE |-> st_reg.digit)
        else $error("digit phase without digit seen");

    // a result mid-string moves the parser to skipping the tail
    a_emit_skip : assert property (@(posedge clk) disable iff (!rst_n)
        consume && emit && char_reg != ttip_pkg::CH_NUL |=>
            st_reg.phase == ttip_pkg::PH_SKIP && out_vld_reg)
        else $error("emit did not enter skip phase");

endmodule
